@@ hdl/zot_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// zot_pkg: shared constants and types for the ADC zero offset tracker
// Default geometry, register indexes and reset values, field widths, and the
// sideband tag that travels down the pipeline with each beat.
// ----------------------------------------------------------------------------
package zot_pkg;

  // default geometry
  localparam int FRAC_BITS_DEF   = 8;
  localparam int SAMPLE_BITS_DEF = 10;
  localparam int SUM_BITS_DEF    = 56;

  // configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 18;

  localparam logic [CFG_INDEX_W-1:0] CFG_INITIAL_OFFSET = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET_STEP    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_LOBE_TOLERANCE = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_FLAT_RUN_LIMIT = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_SNAP_TOLERANCE = 3'd4;

  // register widths
  localparam int INIT_W  = 18;
  localparam int STEP_W  = 8;
  localparam int TOL_W   = 16;
  localparam int LIMIT_W = 8;
  localparam int SNAP_W  = 16;

  // register reset values (initial offset resets to midscale of the offset)
  localparam logic [STEP_W-1:0]  STEP_RESET  = 8'd26;
  localparam logic [TOL_W-1:0]   TOL_RESET   = 16'd10;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd50;
  localparam logic [SNAP_W-1:0]  SNAP_RESET  = 16'd256;

  // fixed field widths
  localparam int TIME_W  = 32;
  localparam int FLAT_W  = 8;
  localparam int COUNT_W = 16;
  localparam int KNOWN_W = 2;

  localparam logic [FLAT_W-1:0]  FLAT_MAX    = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
  localparam logic [KNOWN_W-1:0] KNOWN_NONE  = 2'd0;
  localparam logic [KNOWN_W-1:0] KNOWN_BOTH  = 2'd2;

  // per-beat sideband carried down the pipeline
  typedef struct packed {
    logic crossed;
    logic clear_sums;
  } zot_tag_t;

endpackage
`default_nettype wire

@@ hdl/zot_track.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// zot_track: configuration registers and offset tracking stage
// Holds the offset, crossing history, flat-run and count state; updates them
// for one beat per cycle unless stalled and registers it for squaring.
// ----------------------------------------------------------------------------
module zot_track import zot_pkg::*; #(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [SAMPLE_BITS-1:0] adc_sample,
  input  wire logic [TIME_W-1:0]      time_us,
  input  wire logic                   clear_sums,
  input  wire logic                   restart,
  output logic                        a_valid,
  input  wire logic                   a_stall,
  output logic [SAMPLE_BITS-1:0]      a_sample,
  output logic [SAMPLE_BITS+FRAC_BITS-1:0] a_offset,
  output logic [COUNT_W-1:0]          a_count,
  output zot_tag_t                    a_tag
);

  localparam int OFF_BITS = SAMPLE_BITS + FRAC_BITS;
  localparam int CMP_W    = (OFF_BITS > SNAP_W) ? OFF_BITS : SNAP_W;

  // configuration registers
  logic [OFF_BITS-1:0] init_off;
  logic [STEP_W-1:0]   offset_step;
  logic [TOL_W-1:0]    lobe_tol;
  logic [LIMIT_W-1:0]  flat_limit;
  logic [SNAP_W-1:0]   snap_tol;

  // tracking state
  logic [SAMPLE_BITS-1:0] prev_sample;
  logic                   have_prev;
  logic                   positive_lobe;
  logic [OFF_BITS-1:0]    offset_reg;
  logic [TIME_W-1:0]      last_cross;
  logic [TIME_W-1:0]      lobe_prev;
  logic [KNOWN_W-1:0]     known;
  logic [FLAT_W-1:0]      flat_run;
  logic [COUNT_W-1:0]     count_reg;

  logic                   positive_lobe_next;
  logic [OFF_BITS-1:0]    offset_next;
  logic [TIME_W-1:0]      last_cross_next;
  logic [TIME_W-1:0]      lobe_prev_next;
  logic [KNOWN_W-1:0]     known_next;
  logic [FLAT_W-1:0]      flat_run_next;
  logic [COUNT_W-1:0]     count_next;
  logic                   crossed;

  logic take;

  assign in_stall = a_valid && a_stall;
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      init_off    <= {1'b1, {(OFF_BITS-1){1'b0}}};
      offset_step <= STEP_RESET;
      lobe_tol    <= TOL_RESET;
      flat_limit  <= LIMIT_RESET;
      snap_tol    <= SNAP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INITIAL_OFFSET: init_off    <= OFF_BITS'(cfg_data[INIT_W-1:0]);
        CFG_OFFSET_STEP:    offset_step <= cfg_data[STEP_W-1:0];
        CFG_LOBE_TOLERANCE: lobe_tol    <= cfg_data[TOL_W-1:0];
        CFG_FLAT_RUN_LIMIT: flat_limit  <= cfg_data[LIMIT_W-1:0];
        CFG_SNAP_TOLERANCE: snap_tol    <= cfg_data[SNAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [OFF_BITS-1:0] s_scaled;
    logic [OFF_BITS-1:0] p_scaled;
    logic [OFF_BITS-1:0] off_base;
    logic [OFF_BITS-1:0] off_nudged;
    logic [OFF_BITS:0]   off_sum;
    logic [OFF_BITS-1:0] snap_gap;
    logic [KNOWN_W-1:0]  known_base;
    logic [FLAT_W-1:0]   flat_base;
    logic [FLAT_W-1:0]   flat_inc;
    logic [COUNT_W-1:0]  count_base;
    logic [TIME_W-1:0]   lobe_now;
    logic [TIME_W-1:0]   lobe_gap;
    logic                hp_base;
    logic                cross_up;
    logic                cross_dn;
    logic                go_up;

    s_scaled   = {adc_sample, {FRAC_BITS{1'b0}}};
    p_scaled   = {prev_sample, {FRAC_BITS{1'b0}}};
    off_base   = restart ? init_off : offset_reg;
    known_base = restart ? KNOWN_NONE : known;
    hp_base    = restart ? 1'b0 : have_prev;
    flat_base  = clear_sums ? '0 : flat_run;
    count_base = clear_sums ? '0 : count_reg;

    count_next = (count_base == COUNT_MAX) ? count_base : count_base + 1'b1;

    cross_up = (p_scaled <= off_base) && (s_scaled > off_base);
    cross_dn = (p_scaled >= off_base) && (s_scaled < off_base);
    crossed  = hp_base && (cross_up || cross_dn);

    // lobe durations: the one just closed against the one before it
    lobe_now = time_us - last_cross;
    lobe_gap = (lobe_prev > lobe_now) ? lobe_prev - lobe_now : lobe_now - lobe_prev;

    positive_lobe_next = positive_lobe;
    if (!hp_base) begin
      positive_lobe_next = s_scaled > off_base;
    end else if (cross_up) begin
      positive_lobe_next = 1'b1;
    end else if (cross_dn) begin
      positive_lobe_next = 1'b0;
    end
    go_up = positive_lobe_next == (lobe_prev > lobe_now);

    // nudge only with two earlier crossings and unbalanced lobes
    off_sum    = {1'b0, off_base} + (OFF_BITS+1)'(offset_step);
    off_nudged = off_base;
    if (crossed && (known_base == KNOWN_BOTH) && (lobe_gap >= TIME_W'(lobe_tol))) begin
      if (go_up) begin
        off_nudged = off_sum[OFF_BITS] ? {OFF_BITS{1'b1}} : off_sum[OFF_BITS-1:0];
      end else begin
        off_nudged = (off_base < OFF_BITS'(offset_step)) ? '0
                   : off_base - OFF_BITS'(offset_step);
      end
    end

    last_cross_next = last_cross;
    lobe_prev_next  = lobe_prev;
    known_next      = known_base;
    if (crossed) begin
      last_cross_next = time_us;
      lobe_prev_next  = lobe_now;
      known_next      = (known_base == KNOWN_BOTH) ? known_base : known_base + 1'b1;
    end

    // flat run: snap the offset onto a long run of equal samples
    flat_inc    = (flat_base == FLAT_MAX) ? flat_base : flat_base + 1'b1;
    snap_gap    = (off_nudged > s_scaled) ? off_nudged - s_scaled : s_scaled - off_nudged;
    offset_next = off_nudged;
    if (!hp_base) begin
      flat_run_next = '0;
    end else if (adc_sample == prev_sample) begin
      flat_run_next = flat_inc;
      if ((flat_inc > flat_limit) && (CMP_W'(snap_gap) >= CMP_W'(snap_tol))) begin
        offset_next = s_scaled;
      end
    end else begin
      flat_run_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_sample   <= '0;
      have_prev     <= 1'b0;
      positive_lobe <= 1'b0;
      offset_reg    <= {1'b1, {(OFF_BITS-1){1'b0}}};
      last_cross    <= '0;
      lobe_prev     <= '0;
      known         <= KNOWN_NONE;
      flat_run      <= '0;
      count_reg     <= '0;
      a_valid       <= 1'b0;
    end else begin
      if (!in_stall) begin
        a_valid <= in_valid;
      end
      if (take) begin
        prev_sample   <= adc_sample;
        have_prev     <= 1'b1;
        positive_lobe <= positive_lobe_next;
        offset_reg    <= offset_next;
        last_cross    <= last_cross_next;
        lobe_prev     <= lobe_prev_next;
        known         <= known_next;
        flat_run      <= flat_run_next;
        count_reg     <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      a_sample           <= adc_sample;
      a_offset           <= offset_next;
      a_count            <= count_next;
      a_tag.crossed      <= crossed;
      a_tag.clear_sums   <= clear_sums;
    end
  end

endmodule
`default_nettype wire

@@ hdl/zot_square.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// zot_square: filtered value and squaring stage
// Subtracts the offset from the scaled sample and squares its magnitude.
// ----------------------------------------------------------------------------
module zot_square import zot_pkg::*; #(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   a_valid,
  output logic                        a_stall,
  input  wire logic [SAMPLE_BITS-1:0] a_sample,
  input  wire logic [SAMPLE_BITS+FRAC_BITS-1:0] a_offset,
  input  wire logic [COUNT_W-1:0]     a_count,
  input  wire zot_tag_t               a_tag,
  output logic                        b_valid,
  input  wire logic                   b_stall,
  output logic signed [SAMPLE_BITS+FRAC_BITS:0]   b_filt,
  output logic [SAMPLE_BITS+FRAC_BITS-1:0]        b_offset,
  output logic [2*(SAMPLE_BITS+FRAC_BITS)-1:0]    b_sq,
  output logic [COUNT_W-1:0]          b_count,
  output zot_tag_t                    b_tag
);

  localparam int OFF_BITS = SAMPLE_BITS + FRAC_BITS;

  logic [OFF_BITS-1:0]   s_scaled;
  logic [OFF_BITS-1:0]   mag;
  logic [OFF_BITS:0]     filt;
  logic [2*OFF_BITS-1:0] sq;
  logic                  take;

  assign a_stall  = b_valid && b_stall;
  assign take     = a_valid && !a_stall;
  assign s_scaled = {a_sample, {FRAC_BITS{1'b0}}};
  assign filt     = {1'b0, s_scaled} - {1'b0, a_offset};
  assign mag      = (s_scaled > a_offset) ? s_scaled - a_offset : a_offset - s_scaled;
  assign sq       = (2*OFF_BITS)'(mag) * (2*OFF_BITS)'(mag);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (!a_stall) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      b_filt   <= filt;
      b_offset <= a_offset;
      b_sq     <= sq;
      b_count  <= a_count;
      b_tag    <= a_tag;
    end
  end

endmodule
`default_nettype wire

@@ hdl/zot_accum.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// zot_accum: sum of squares and result register
// Adds each square into the saturating sum and holds the result beat.
// ----------------------------------------------------------------------------
module zot_accum import zot_pkg::*; #(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int SUM_BITS    = SUM_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   b_valid,
  output logic                        b_stall,
  input  wire logic signed [SAMPLE_BITS+FRAC_BITS:0]   b_filt,
  input  wire logic [SAMPLE_BITS+FRAC_BITS-1:0]        b_offset,
  input  wire logic [2*(SAMPLE_BITS+FRAC_BITS)-1:0]    b_sq,
  input  wire logic [COUNT_W-1:0]     b_count,
  input  wire zot_tag_t               b_tag,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic signed [SAMPLE_BITS+FRAC_BITS:0] filtered_value,
  output logic [SAMPLE_BITS+FRAC_BITS-1:0]      offset_now,
  output logic                        crossed,
  output logic [SUM_BITS-1:0]         square_sum,
  output logic [COUNT_W-1:0]          sample_count
);

  localparam int SQ_W  = 2 * (SAMPLE_BITS + FRAC_BITS);
  localparam int ACC_W = ((SUM_BITS > SQ_W) ? SUM_BITS : SQ_W) + 1;

  logic [SUM_BITS-1:0] sum_reg;
  logic [SUM_BITS-1:0] sum_next;
  logic [SUM_BITS-1:0] sum_base;
  logic [ACC_W-1:0]    sum_wide;
  logic                take;

  assign b_stall    = out_valid && out_stall;
  assign take       = b_valid && !b_stall;
  assign sum_base   = b_tag.clear_sums ? '0 : sum_reg;
  assign sum_wide   = ACC_W'(sum_base) + ACC_W'(b_sq);
  assign sum_next   = (sum_wide > ACC_W'({SUM_BITS{1'b1}})) ? {SUM_BITS{1'b1}}
                    : sum_wide[SUM_BITS-1:0];
  assign square_sum = sum_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sum_reg   <= '0;
    end else begin
      if (!b_stall) begin
        out_valid <= b_valid;
      end
      if (take) begin
        sum_reg <= sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      filtered_value <= b_filt;
      offset_now     <= b_offset;
      crossed        <= b_tag.crossed;
      sample_count   <= b_count;
    end
  end

endmodule
`default_nettype wire

@@ hdl/adc_zero_offset_tracker_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// adc_zero_offset_tracker_unit: ADC zero offset tracker, top level
// Tracks the zero offset of a sampled waveform and reports the filtered
// sample, the offset, crossings, a running sum of squares and a count.
// ----------------------------------------------------------------------------
// Each input beat carries one raw sample and its microsecond time stamp. The
// block accepts one beat per clock unless stalled and returns exactly one
// result beat for it; results come out in input order. Throughput is set by
// the offset feedback loop in the tracking stage (restart, crossing test, lobe
// compare, nudge and flat-run snap all settle combinationally) and by the
// sum-of-squares loop in the accumulate stage. Each of the three stages holds
// its own beat, so a stall on the output only stops input once all three are
// full. Write configuration registers through cfg_we/cfg_index/cfg_data only
// while no beat is in flight; the block does not enforce this. Indexes are
// initial offset, offset step, lobe tolerance, flat run limit, snap tolerance.
// ----------------------------------------------------------------------------
module adc_zero_offset_tracker_unit import zot_pkg::*; #(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int SUM_BITS    = SUM_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // configuration write port
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  // sample channel
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [SAMPLE_BITS-1:0] adc_sample,
  input  wire logic [TIME_W-1:0]      time_us,
  input  wire logic                   clear_sums,
  input  wire logic                   restart,
  // result channel
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic signed [SAMPLE_BITS+FRAC_BITS:0] filtered_value,
  output logic [SAMPLE_BITS+FRAC_BITS-1:0]      offset_now,
  output logic                        crossed,
  output logic [SUM_BITS-1:0]         square_sum,
  output logic [COUNT_W-1:0]          sample_count
);

  localparam int OFF_BITS = SAMPLE_BITS + FRAC_BITS;

  // tracking stage -> squaring stage
  logic                   a_valid;
  logic                   a_stall;
  logic [SAMPLE_BITS-1:0] a_sample;
  logic [OFF_BITS-1:0]    a_offset;
  logic [COUNT_W-1:0]     a_count;
  zot_tag_t               a_tag;

  // squaring stage -> accumulate stage
  logic                   b_valid;
  logic                   b_stall;
  logic signed [OFF_BITS:0] b_filt;
  logic [OFF_BITS-1:0]    b_offset;
  logic [2*OFF_BITS-1:0]  b_sq;
  logic [COUNT_W-1:0]     b_count;
  zot_tag_t               b_tag;

  // Stage 1: update offset, crossing history, flat run and count.
  zot_track #(
    .FRAC_BITS   (FRAC_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_track (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .adc_sample (adc_sample),
    .time_us    (time_us),
    .clear_sums (clear_sums),
    .restart    (restart),
    .a_valid    (a_valid),
    .a_stall    (a_stall),
    .a_sample   (a_sample),
    .a_offset   (a_offset),
    .a_count    (a_count),
    .a_tag      (a_tag)
  );

  // Stage 2: filtered value and its square (the single multiplier).
  zot_square #(
    .FRAC_BITS   (FRAC_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_square (
    .clk      (clk),
    .rst      (rst),
    .a_valid  (a_valid),
    .a_stall  (a_stall),
    .a_sample (a_sample),
    .a_offset (a_offset),
    .a_count  (a_count),
    .a_tag    (a_tag),
    .b_valid  (b_valid),
    .b_stall  (b_stall),
    .b_filt   (b_filt),
    .b_offset (b_offset),
    .b_sq     (b_sq),
    .b_count  (b_count),
    .b_tag    (b_tag)
  );

  // Stage 3: saturating sum of squares; also the result register.
  zot_accum #(
    .FRAC_BITS   (FRAC_BITS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .SUM_BITS    (SUM_BITS)
  ) u_accum (
    .clk            (clk),
    .rst            (rst),
    .b_valid        (b_valid),
    .b_stall        (b_stall),
    .b_filt         (b_filt),
    .b_offset       (b_offset),
    .b_sq           (b_sq),
    .b_count        (b_count),
    .b_tag          (b_tag),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .filtered_value (filtered_value),
    .offset_now     (offset_now),
    .crossed        (crossed),
    .square_sum     (square_sum),
    .sample_count   (sample_count)
  );

endmodule
`default_nettype wire

@@ hdl/zot_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// zot_port_checks: port-level checks for the zero offset tracker
// Watches the result channel and the input stall over time; bound to the top
// level.
// ----------------------------------------------------------------------------
module zot_port_checks import zot_pkg::*; #(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int SUM_BITS    = SUM_BITS_DEF
) (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   in_stall,
  input wire logic                   out_valid,
  input wire logic                   out_stall,
  input wire logic signed [SAMPLE_BITS+FRAC_BITS:0] filtered_value,
  input wire logic [SAMPLE_BITS+FRAC_BITS-1:0]      offset_now,
  input wire logic                   crossed,
  input wire logic [SUM_BITS-1:0]    square_sum,
  input wire logic [COUNT_W-1:0]     sample_count
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(filtered_value) &&
      $stable(offset_now) && $stable(crossed) && $stable(square_sum) &&
      $stable(sample_count))
    else $error("stalled result beat changed");

  // nothing comes out in the cycle after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result beat right after reset");

  // every result counts at least its own sample
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> sample_count != '0)
    else $error("result beat with zero sample count");

  // first sample after a clear with zero filtered value leaves an empty sum
  a_sum_fresh: assert property (@(posedge clk) disable iff (rst)
    out_valid && (sample_count == COUNT_W'(1)) && (filtered_value == '0)
      |-> square_sum == '0)
    else $error("sum not empty on first zero sample");

  // input only stalls behind a full, stalled result register
  a_in_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with the result side free");

endmodule

bind adc_zero_offset_tracker_unit zot_port_checks #(
  .FRAC_BITS   (FRAC_BITS),
  .SAMPLE_BITS (SAMPLE_BITS),
  .SUM_BITS    (SUM_BITS)
) u_zot_checker (
  .clk            (clk),
  .rst            (rst),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .filtered_value (filtered_value),
  .offset_now     (offset_now),
  .crossed        (crossed),
  .square_sum     (square_sum),
  .sample_count   (sample_count)
);
`default_nettype wire

@@ tb/zot_checker.sv @@
// ----------------------------------------------------------------------------
// zot_checker: result predictor and scoreboard for the zero offset tracker
// Mirrors the register writes, predicts one result beat per accepted sample
// beat and compares every result beat, field by field, in arrival order.
// ----------------------------------------------------------------------------
module zot_checker
  import zot_pkg::*;
(
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [CFG_INDEX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]           cfg_data,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [SAMPLE_BITS_DEF-1:0]      adc_sample,
  input  logic [TIME_W-1:0]               time_us,
  input  logic                            clear_sums,
  input  logic                            restart,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic signed [SAMPLE_BITS_DEF+FRAC_BITS_DEF:0] filtered_value,
  input  logic [SAMPLE_BITS_DEF+FRAC_BITS_DEF-1:0]      offset_now,
  input  logic                            crossed,
  input  logic [SUM_BITS_DEF-1:0]         square_sum,
  input  logic [COUNT_W-1:0]              sample_count,
  output int                              pending,
  output int                              fail_count
);

  localparam int OFF_W = SAMPLE_BITS_DEF + FRAC_BITS_DEF;
  localparam logic [63:0] OFF_LIMIT = (64'd1 << OFF_W) - 64'd1;
  localparam logic [63:0] SUM_LIMIT = (64'd1 << SUM_BITS_DEF) - 64'd1;
  localparam logic [OFF_W-1:0] OFFSET_RESET = 1 << (OFF_W - 1);
  localparam int SHOW_LIMIT = 10;

  typedef struct packed {
    logic signed [OFF_W:0]     filt;
    logic [OFF_W-1:0]          offset;
    logic                      crossed;
    logic [SUM_BITS_DEF-1:0]   sum;
    logic [COUNT_W-1:0]        count;
  } tracker_beat_t;

  // register copies
  logic [INIT_W-1:0]  init_offset;
  logic [STEP_W-1:0]  nudge_step;
  logic [TOL_W-1:0]   lobe_tol;
  logic [LIMIT_W-1:0] flat_limit;
  logic [SNAP_W-1:0]  snap_tol;

  // tracker state
  logic [SAMPLE_BITS_DEF-1:0] prior_smp;
  logic                       have_last;
  logic                       high_lobe;
  logic [OFF_W-1:0]           offset_q;
  logic [TIME_W-1:0]          cross_t [2];
  logic [KNOWN_W-1:0]         cross_known;
  logic [FLAT_W-1:0]          flat_len;
  logic [SUM_BITS_DEF-1:0]    sq_acc;
  logic [COUNT_W-1:0]         n_samples;

  tracker_beat_t tracker_results_due [$];
  int mismatches = 0;

  task automatic track_sample(input logic [SAMPLE_BITS_DEF-1:0] smp,
                              input logic [TIME_W-1:0] stamp,
                              input logic clr, input logic rs,
                              output tracker_beat_t res);
    logic [63:0] s, p, off, mag, sq, dd;
    logic [TIME_W-1:0] d0, d1;
    logic hit, up;
    s = 64'(smp) << FRAC_BITS_DEF;
    hit = 1'b0;
    if (rs) begin
      offset_q = init_offset;
      cross_known = KNOWN_NONE;
      have_last = 1'b0;
    end
    if (clr) begin
      sq_acc = '0;
      n_samples = '0;
      flat_len = '0;
    end
    if (!have_last) begin
      high_lobe = s > offset_q;
      flat_len = '0;
    end else begin
      p = 64'(prior_smp) << FRAC_BITS_DEF;
      if (p <= offset_q && s > offset_q) begin
        hit = 1'b1;
        high_lobe = 1'b1;
      end else if (p >= offset_q && s < offset_q) begin
        hit = 1'b1;
        high_lobe = 1'b0;
      end
      if (hit) begin
        // compare the two lobes before this crossing, durations wrap at 2^32
        if (cross_known == KNOWN_BOTH) begin
          d0 = cross_t[1] - cross_t[0];
          d1 = stamp - cross_t[1];
          dd = (d0 > d1) ? 64'(d0 - d1) : 64'(d1 - d0);
          if (dd >= lobe_tol) begin
            up = high_lobe ? (d0 > d1) : !(d0 > d1);
            off = offset_q;
            if (up) off = (off + nudge_step > OFF_LIMIT) ? OFF_LIMIT : off + nudge_step;
            else off = (off < nudge_step) ? 64'd0 : off - nudge_step;
            offset_q = off[OFF_W-1:0];
          end
        end
        cross_t[0] = cross_t[1];
        cross_t[1] = stamp;
        if (cross_known != KNOWN_BOTH) cross_known = cross_known + 1'b1;
      end
      if (smp == prior_smp) begin
        if (flat_len != FLAT_MAX) flat_len = flat_len + 1'b1;
        mag = (offset_q > s) ? offset_q - s : s - offset_q;
        if (flat_len > flat_limit && mag >= snap_tol) offset_q = s[OFF_W-1:0];
      end else begin
        flat_len = '0;
      end
    end
    prior_smp = smp;
    have_last = 1'b1;
    mag = (offset_q > s) ? offset_q - s : s - offset_q;
    sq = mag * mag;
    sq_acc = (64'(sq_acc) > SUM_LIMIT - sq) ? SUM_LIMIT[SUM_BITS_DEF-1:0]
                                            : sq_acc + sq[SUM_BITS_DEF-1:0];
    if (n_samples != COUNT_MAX) n_samples = n_samples + 1'b1;
    res.filt = (OFF_W+1)'(s - 64'(offset_q));
    res.offset = offset_q;
    res.crossed = hit;
    res.sum = sq_acc;
    res.count = n_samples;
  endtask

  always @(posedge clk) begin : watch
    tracker_beat_t seen, due, fresh;
    if (rst) begin
      init_offset = OFFSET_RESET;
      nudge_step = STEP_RESET;
      lobe_tol = TOL_RESET;
      flat_limit = LIMIT_RESET;
      snap_tol = SNAP_RESET;
      prior_smp = '0;
      have_last = 1'b0;
      high_lobe = 1'b0;
      offset_q = OFFSET_RESET;
      cross_t[0] = '0;
      cross_t[1] = '0;
      cross_known = KNOWN_NONE;
      flat_len = '0;
      sq_acc = '0;
      n_samples = '0;
      tracker_results_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_INITIAL_OFFSET: init_offset = cfg_data[INIT_W-1:0];
          CFG_OFFSET_STEP:    nudge_step = cfg_data[STEP_W-1:0];
          CFG_LOBE_TOLERANCE: lobe_tol = cfg_data[TOL_W-1:0];
          CFG_FLAT_RUN_LIMIT: flat_limit = cfg_data[LIMIT_W-1:0];
          CFG_SNAP_TOLERANCE: snap_tol = cfg_data[SNAP_W-1:0];
          default: ;
        endcase
      end
      // retire the oldest prediction before queuing a new one
      if (out_valid && !out_stall) begin
        seen = '{filtered_value, offset_now, crossed, square_sum, sample_count};
        if (tracker_results_due.size() == 0) begin
          if (mismatches < SHOW_LIMIT)
            $display("unexpected result beat: filtered %0d offset %0d crossed %0b sum %0d count %0d",
                     seen.filt, seen.offset, seen.crossed, seen.sum, seen.count);
          mismatches++;
        end else begin
          due = tracker_results_due.pop_front();
          if (seen.filt !== due.filt || seen.offset !== due.offset ||
              seen.crossed !== due.crossed || seen.sum !== due.sum ||
              seen.count !== due.count) begin
            if (mismatches < SHOW_LIMIT)
              $display({"result mismatch: filtered exp %0d got %0d, offset exp %0d got %0d,",
                        " crossed exp %0b got %0b, sum exp %0d got %0d, count exp %0d got %0d"},
                       due.filt, seen.filt, due.offset, seen.offset, due.crossed, seen.crossed,
                       due.sum, seen.sum, due.count, seen.count);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        track_sample(adc_sample, time_us, clear_sums, restart, fresh);
        tracker_results_due.push_back(fresh);
      end
    end
    pending <= tracker_results_due.size();
    fail_count <= mismatches + tracker_results_due.size();
  end

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for adc_zero_offset_tracker_unit
// Drives directed and waveform-shaped random sample beats under several
// register settings, with random gaps and output stalls, while zot_checker
// predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb;
  import zot_pkg::*;

  localparam int OFF_W = SAMPLE_BITS_DEF + FRAC_BITS_DEF;
  localparam int LIMIT_CYCLES = 800_000;
  localparam int SAMPLE_TOP = (1 << SAMPLE_BITS_DEF) - 1;

  logic                            clk;
  logic                            rst;
  logic                            cfg_we;
  logic [CFG_INDEX_W-1:0]          cfg_index;
  logic [CFG_DATA_W-1:0]           cfg_data;
  logic                            in_valid;
  logic                            in_stall;
  logic [SAMPLE_BITS_DEF-1:0]      adc_sample;
  logic [TIME_W-1:0]               time_us;
  logic                            clear_sums;
  logic                            restart;
  logic                            out_valid;
  logic                            out_stall;
  logic signed [OFF_W:0]           filtered_value;
  logic [OFF_W-1:0]                offset_now;
  logic                            crossed;
  logic [SUM_BITS_DEF-1:0]         square_sum;
  logic [COUNT_W-1:0]              sample_count;

  int          pending;
  int          fail_count;
  logic [31:0] stamp;             // running sample time for the waveform beats
  bit          quiet_out = 1'b0;  // hold the result side free of stalls
  int unsigned cycle_count = 0;

  adc_zero_offset_tracker_unit dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .adc_sample(adc_sample), .time_us(time_us),
    .clear_sums(clear_sums), .restart(restart),
    .out_valid(out_valid), .out_stall(out_stall),
    .filtered_value(filtered_value), .offset_now(offset_now), .crossed(crossed),
    .square_sum(square_sum), .sample_count(sample_count)
  );

  zot_checker scoreboard (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .adc_sample(adc_sample), .time_us(time_us),
    .clear_sums(clear_sums), .restart(restart),
    .out_valid(out_valid), .out_stall(out_stall),
    .filtered_value(filtered_value), .offset_now(offset_now), .crossed(crossed),
    .square_sum(square_sum), .sample_count(sample_count),
    .pending(pending), .fail_count(fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run once the cycle limit is reached.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Gap length: mostly short, now and then a long one. Never zero, so
  // a signal is never assigned twice in one time step.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [SAMPLE_BITS_DEF-1:0] clamp_sample(input int v);
    if (v < 0) return '0;
    if (v > SAMPLE_TOP) return SAMPLE_TOP[SAMPLE_BITS_DEF-1:0];
    return v[SAMPLE_BITS_DEF-1:0];
  endfunction

  // Back-pressure on the result side: free stretches, some of them long,
  // broken by stalls of random length.
  initial begin : result_backpressure
    int unsigned run_len;
    out_stall <= 1'b0;
    forever begin
      if (quiet_out) begin
        @(posedge clk);
      end else begin
        run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : gap_len();
        repeat (run_len) @(posedge clk);
        out_stall <= 1'b1;
        repeat (gap_len()) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Write one register, then drop the enable and wait so back-to-back writes
  // never raise and lower the enable in the same step.
  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input int unsigned val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input int unsigned init_off, input int unsigned step,
                            input int unsigned tol, input int unsigned limit,
                            input int unsigned snap);
    cfg_write(CFG_INITIAL_OFFSET, init_off);
    cfg_write(CFG_OFFSET_STEP, step);
    cfg_write(CFG_LOBE_TOLERANCE, tol);
    cfg_write(CFG_FLAT_RUN_LIMIT, limit);
    cfg_write(CFG_SNAP_TOLERANCE, snap);
  endtask

  // Present one beat and hold it until the edge that accepts it.
  task automatic send_beat(input logic [SAMPLE_BITS_DEF-1:0] smp, input logic [31:0] t,
                           input logic clr, input logic rs);
    in_valid <= 1'b1;
    adc_sample <= smp;
    time_us <= t;
    clear_sums <= clr;
    restart <= rs;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic idle(input int unsigned n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic push_sample(input logic [SAMPLE_BITS_DEF-1:0] smp, input logic [31:0] t,
                             input logic clr, input logic rs, input int idle_pct);
    send_beat(smp, t, clr, rs);
    if ($urandom_range(0, 99) < idle_pct) idle(gap_len());
  endtask

  // Stop sending and wait for every predicted result to come back, then let
  // the pipeline settle.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  // One waveform beat: advance the time stamp (mostly small steps, some
  // large, a few wrapping jumps) and throw in rare clears and restarts.
  task automatic wave_beat(input logic [SAMPLE_BITS_DEF-1:0] smp, input int idle_pct,
                           input int clear_odds);
    int unsigned r;
    logic clr, rs;
    r = $urandom_range(0, 99);
    if (r < 90) stamp += $urandom_range(1, 50);
    else if (r < 98) stamp += $urandom_range(51, 3000);
    else stamp += $urandom;
    clr = (clear_odds != 0) && ($urandom_range(1, clear_odds) == 1);
    rs = ($urandom_range(0, 99) == 0);
    push_sample(smp, stamp, clr, rs, idle_pct);
    // now and then pause the sender until every result is back
    if (idle_pct != 0 && $urandom_range(0, 199) == 0) drain();
  endtask

  // Mostly a square-ish wave around center with random lobe lengths, so
  // crossings and lobe comparisons happen often; mixed with flat runs that
  // reach past the run limit and with noise samples.
  task automatic run_wave(input int n, input int center, input int amp, input int idle_pct,
                          input int clear_odds, input int flat_hint);
    int sent;
    int unsigned pick, len;
    int lvl;
    bit high;
    sent = 0;
    high = $urandom_range(0, 1);
    while (sent < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        len = $urandom_range(1, flat_hint);
        lvl = center + int'($urandom_range(0, 2 * amp)) - amp;
        repeat (len) begin
          wave_beat(clamp_sample(lvl), idle_pct, clear_odds);
          sent++;
        end
      end else if (pick < 12) begin
        wave_beat(SAMPLE_BITS_DEF'($urandom_range(0, SAMPLE_TOP)), idle_pct, clear_odds);
        sent++;
      end else begin
        high = !high;
        len = $urandom_range(1, 6);
        repeat (len) begin
          lvl = high ? center + int'($urandom_range(1, amp))
                     : center - int'($urandom_range(1, amp));
          wave_beat(clamp_sample(lvl), idle_pct, clear_odds);
          sent++;
        end
      end
    end
  endtask

  initial begin : stimulus
    int unsigned init_pick, tol_pick, snap_pick, limit_pick;
    int idle_pick;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= CFG_INITIAL_OFFSET;
    cfg_data <= '0;
    in_valid <= 1'b0;
    adc_sample <= '0;
    time_us <= '0;
    clear_sums <= 1'b0;
    restart <= 1'b0;
    stamp = $urandom;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed, reset register values (offset at sample 512) ----
    // first sample with restart and clear together, bottom of the range
    push_sample(10'd0, 32'd0, 1'b1, 1'b1, 40);
    // up and down crossings: fewer than two known, so just record times
    push_sample(10'd1023, 32'd100, 1'b0, 1'b0, 40);
    push_sample(10'd0, 32'd200, 1'b0, 1'b0, 40);
    // unbalanced lobes on entering each lobe: nudge
    push_sample(10'd1023, 32'd350, 1'b0, 1'b0, 40);
    push_sample(10'd0, 32'd400, 1'b0, 1'b0, 40);
    // lobe difference exactly at the tolerance nudges, one below does not
    push_sample(10'd1023, 32'd460, 1'b0, 1'b0, 40);
    push_sample(10'd0, 32'd529, 1'b0, 1'b0, 40);
    // restart on a sample equal to the offset, then cross up out of it
    push_sample(10'd512, 32'hFFFF_FF00, 1'b0, 1'b1, 40);
    push_sample(10'd600, 32'hFFFF_FF80, 1'b0, 1'b0, 40);
    // land on the offset (no crossing), then cross down past the time wrap
    push_sample(10'd512, 32'hFFFF_FFFF, 1'b0, 1'b0, 40);
    push_sample(10'd400, 32'h0000_0040, 1'b0, 1'b0, 40);
    // lobe durations measured across the wrap, the longer one first: nudge up
    push_sample(10'd700, 32'h0000_00A0, 1'b0, 1'b0, 40);
    // clear on a repeated sample
    push_sample(10'd700, 32'h0000_00B0, 1'b1, 1'b0, 40);

    // random waveform under reset register values, flat runs past the limit
    run_wave(120, 512, 100, 30, 40, int'(LIMIT_RESET) + 6);
    drain();

    // ---- directed: a nudge down that saturates the offset at zero ----
    set_config(100, 255, 0, LIMIT_RESET, SNAP_RESET);
    push_sample(10'd0, 32'd0, 1'b0, 1'b1, 40);
    push_sample(10'd1, 32'd10, 1'b0, 1'b0, 40);
    push_sample(10'd0, 32'd20, 1'b0, 1'b0, 40);
    push_sample(10'd1, 32'd40, 1'b0, 1'b0, 40);
    drain();

    // ---- low extremes: every crossing with two earlier ones known nudges by
    // the largest step, every repeated sample may snap ----
    set_config(0, 255, 0, 0, 0);
    run_wave(80, 512, 60, 20, 25, 4);
    drain();

    // ---- high extremes: offset at the top, no nudge, no snap ----
    set_config((1 << INIT_W) - 1, 0, (1 << TOL_W) - 1, (1 << LIMIT_W) - 1,
               (1 << SNAP_W) - 1);
    run_wave(60, 512, 300, 40, 20, 60);
    drain();

    // ---- back-to-back run with no clears, result side held free ----
    set_config(1 << (OFF_W - 1), STEP_RESET, TOL_RESET, LIMIT_RESET, SNAP_RESET);
    quiet_out <= 1'b1;
    run_wave(30, 512, 150, 0, 0, 20);
    drain();
    quiet_out <= 1'b0;

    // ---- random register settings ----
    for (int ph = 0; ph < 3; ph++) begin
      init_pick = $urandom_range(25600, 236543);
      tol_pick = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 300);
      snap_pick = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 2048);
      limit_pick = $urandom_range(0, 12);
      case ($urandom_range(0, 2))
        0: idle_pick = 0;
        1: idle_pick = 15;
        default: idle_pick = 45;
      endcase
      set_config(init_pick, $urandom_range(0, 255), tol_pick, limit_pick, snap_pick);
      run_wave(120, int'(init_pick >> FRAC_BITS_DEF), $urandom_range(2, 200), idle_pick, 30,
               limit_pick + 6);
      drain();
    end

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
